/* rtl/owrom_pkg.sv */
// Package for the 1-Wire slave ROM command layer.
// Holds the transaction payload types, configuration types and command codes.
// No dependencies.
package owrom_pkg;

  localparam int RomBits   = 64;
  localparam int RomBytes  = RomBits / 8;
  localparam int BitIdxW   = $clog2(RomBits);
  localparam int ByteIdxW  = $clog2(RomBytes);
  localparam int ReplyW    = ByteIdxW + 1;
  localparam int CfgIdxW   = 1;

  // Event kinds
  localparam logic [2:0] KIND_BUS_RESET    = 3'd0;
  localparam logic [2:0] KIND_WRITE_BYTE   = 3'd1;
  localparam logic [2:0] KIND_READ_BYTE    = 3'd2;
  localparam logic [2:0] KIND_SEARCH_READ  = 3'd3;
  localparam logic [2:0] KIND_SEARCH_WRITE = 3'd4;

  // ROM commands
  localparam logic [7:0] CMD_READ_ROM       = 8'h33;
  localparam logic [7:0] CMD_MATCH_ROM      = 8'h55;
  localparam logic [7:0] CMD_OD_MATCH_ROM   = 8'h69;
  localparam logic [7:0] CMD_SEARCH_ROM     = 8'hF0;
  localparam logic [7:0] CMD_SKIP_ROM       = 8'hCC;
  localparam logic [7:0] CMD_OD_SKIP_ROM    = 8'h3C;
  localparam logic [7:0] CMD_RESUME         = 8'hA5;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ROM_ADDRESS  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_IS_CONNECTED = 1'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       dir_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
    logic       still_active;
    logic       fn_byte_valid;
    logic [7:0] fn_byte;
  } out_item_t;

  typedef struct packed {
    logic [RomBits-1:0] rom_address;
    logic               is_connected;
  } cfg_t;

endpackage

/* rtl/onewire_slave_rom_layer.sv */
// Top level of the 1-Wire slave ROM command layer.
// Depends on owrom_pkg, owrom_cfg and owrom_core.
//
// One bus event (bus reset, byte write, byte read, search read, search
// write) enters per transaction and yields exactly one result transaction.
// Each event is held in an input register, processed by the command logic
// and placed in an output register, so a new event is taken every cycle
// while the result side keeps up; out_valid rises once the result is in
// the output register. in_stall rises only when the output register is
// full and stalled. Configuration writes (index 0 ROM code, index 1
// connected flag) are always ready and take effect the next cycle; issue
// them only while no event is in flight.
module onewire_slave_rom_layer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  owrom_pkg::in_item_t             in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output owrom_pkg::out_item_t            out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [owrom_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [owrom_pkg::RomBits-1:0]   cfg_data
);

  logic                 in_full_r, in_full_nxt;
  owrom_pkg::in_item_t  in_item_r;
  logic                 out_valid_r, out_valid_nxt;
  owrom_pkg::out_item_t out_item_r;
  owrom_pkg::out_item_t result;
  owrom_pkg::cfg_t      cfg;
  logic                 advance;
  logic                 in_take;

  assign cfg_ready = 1'b1;

  owrom_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owrom_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // advance the held event when the output register is free or draining
  assign advance  = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_take) begin
      in_full_nxt = 1'b1;
    end else if (advance) begin
      in_full_nxt = 1'b0;
    end
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/owrom_cfg.sv */
// Configuration registers of the 1-Wire slave ROM layer.
// Depends on owrom_pkg for the register indexes and the cfg_t bundle.
module owrom_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [owrom_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [owrom_pkg::RomBits-1:0]   wr_data,
  output owrom_pkg::cfg_t                 cfg
);

  logic [owrom_pkg::RomBits-1:0] rom_address_r;
  logic                          is_connected_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_address_r  <= '0;
      is_connected_r <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        owrom_pkg::REG_ROM_ADDRESS:  rom_address_r  <= wr_data;
        owrom_pkg::REG_IS_CONNECTED: is_connected_r <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.rom_address  = rom_address_r;
  assign cfg.is_connected = is_connected_r;

endmodule

/* rtl/owrom_core.sv */
// ROM command state and per-event logic of the 1-Wire slave ROM layer.
// Depends on owrom_pkg for payload types, command codes and sizes.
module owrom_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  owrom_pkg::in_item_t   item,
  input  owrom_pkg::cfg_t       cfg,
  output owrom_pkg::out_item_t  result
);

  logic [owrom_pkg::ReplyW-1:0]   reply_left_r, reply_left_nxt;
  logic [owrom_pkg::ByteIdxW-1:0] match_count_r, match_count_nxt;
  logic [owrom_pkg::RomBits-1:0]  match_buf_r, match_buf_nxt;
  logic                           collecting_r, collecting_nxt;
  logic                           dropped_r, dropped_nxt;
  logic                           selected_r, selected_nxt;
  logic [owrom_pkg::BitIdxW-1:0]  bit_idx_r, bit_idx_nxt;

  logic                           rom_bit;
  logic [owrom_pkg::ByteIdxW-1:0] reply_idx;
  logic [owrom_pkg::ReplyW-1:0]   reply_sub;

  assign rom_bit   = cfg.rom_address[bit_idx_r];
  assign reply_sub = owrom_pkg::ReplyW'(owrom_pkg::RomBytes) - reply_left_r;
  assign reply_idx = reply_sub[owrom_pkg::ByteIdxW-1:0];

  always_comb begin
    reply_left_nxt  = reply_left_r;
    match_count_nxt = match_count_r;
    match_buf_nxt   = match_buf_r;
    collecting_nxt  = collecting_r;
    dropped_nxt     = dropped_r;
    selected_nxt    = selected_r;
    bit_idx_nxt     = bit_idx_r;

    result.read_byte     = owrom_pkg::IDLE_BYTE;
    result.presence      = 1'b0;
    result.id_bit        = 1'b1;
    result.cmp_bit       = 1'b1;
    result.still_active  = 1'b0;
    result.fn_byte_valid = 1'b0;
    result.fn_byte       = 8'd0;

    case (item.kind)
      owrom_pkg::KIND_BUS_RESET: begin
        dropped_nxt     = 1'b0;
        selected_nxt    = 1'b0;
        reply_left_nxt  = '0;
        collecting_nxt  = 1'b0;
        match_count_nxt = '0;
        result.presence = cfg.is_connected;
      end
      owrom_pkg::KIND_WRITE_BYTE: begin
        if (!dropped_r && cfg.is_connected) begin
          if (collecting_r) begin
            match_buf_nxt[match_count_r*8 +: 8] = item.data_byte;
            match_count_nxt = match_count_r + 1'b1;
            // last match byte: compare the whole code and select or drop
            if (&match_count_r) begin
              collecting_nxt = 1'b0;
              dropped_nxt    = (match_buf_nxt != cfg.rom_address);
              selected_nxt   = (match_buf_nxt == cfg.rom_address);
            end
          end else if (selected_r) begin
            result.fn_byte_valid = 1'b1;
            result.fn_byte       = item.data_byte;
          end else begin
            case (item.data_byte)
              owrom_pkg::CMD_READ_ROM:
                reply_left_nxt = owrom_pkg::ReplyW'(owrom_pkg::RomBytes);
              owrom_pkg::CMD_MATCH_ROM, owrom_pkg::CMD_OD_MATCH_ROM: begin
                collecting_nxt  = 1'b1;
                match_count_nxt = '0;
              end
              owrom_pkg::CMD_SEARCH_ROM: bit_idx_nxt = '0;
              owrom_pkg::CMD_SKIP_ROM, owrom_pkg::CMD_OD_SKIP_ROM,
              owrom_pkg::CMD_RESUME: selected_nxt = 1'b1;
              default: ;
            endcase
          end
        end
      end
      owrom_pkg::KIND_READ_BYTE: begin
        if (reply_left_r != '0) begin
          result.read_byte = cfg.rom_address[reply_idx*8 +: 8];
          reply_left_nxt   = reply_left_r - 1'b1;
        end
      end
      owrom_pkg::KIND_SEARCH_READ: begin
        if (!dropped_r) begin
          result.id_bit  = !rom_bit;
          result.cmp_bit = rom_bit;
        end
      end
      owrom_pkg::KIND_SEARCH_WRITE: begin
        dropped_nxt = dropped_r || (rom_bit != item.dir_bit);
        // hold at the last bit
        if (!(&bit_idx_r)) begin
          bit_idx_nxt = bit_idx_r + 1'b1;
        end
        result.still_active = !dropped_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_left_r  <= '0;
      match_count_r <= '0;
      collecting_r  <= 1'b0;
      dropped_r     <= 1'b0;
      selected_r    <= 1'b0;
      bit_idx_r     <= '0;
    end else if (step_en) begin
      reply_left_r  <= reply_left_nxt;
      match_count_r <= match_count_nxt;
      collecting_r  <= collecting_nxt;
      dropped_r     <= dropped_nxt;
      selected_r    <= selected_nxt;
      bit_idx_r     <= bit_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      match_buf_r <= match_buf_nxt;
    end
  end

endmodule
